FILE: hw/rtl/tcgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants of the text console glyph renderer
// Transfer codes, character codes, the font memory geometry and the structs
// that travel between the controller, the font memory and the top level.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // Font memory geometry.
    localparam int FONT_AW    = 11;
    localparam int FONT_DEPTH = 1 << FONT_AW;

    // Glyphs are always eight pixels wide.
    localparam int GLYPH_COLS      = 8;
    localparam int GLYPH_COL_SHIFT = 3;

    // Internal width of pixel coordinates and damage bounds.
    localparam int DIM_W = 11;

    // Input item kinds.
    typedef enum logic [1:0] {
        IN_LOAD  = 2'd0,
        IN_PUT   = 2'd1,
        IN_FLUSH = 2'd2
    } in_kind_t;

    // Result item kinds.
    typedef enum logic [1:0] {
        OUT_ROW    = 2'd0,
        OUT_SCROLL = 2'd1,
        OUT_RECT   = 2'd2
    } out_kind_t;

    // Character codes with special handling.
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_MAX   = 8'd127;

    // One result item.
    typedef struct packed {
        logic [1:0] out_kind;
        logic [9:0] pixel_x;
        logic [8:0] pixel_y;
        logic [7:0] row_bits;
        logic [9:0] rect_width;
        logic [8:0] rect_height;
        logic       last;
    } result_t;

    // A result issued by the controller; when from_ram is set, row bits come from the font memory.
    typedef struct packed {
        logic    valid;
        logic    from_ram;
        result_t res;
    } issue_t;

    // Font memory access request.
    typedef struct packed {
        logic               we;
        logic [FONT_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [FONT_AW-1:0] raddr;
    } font_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/text_console_glyph_renderer.sv
`default_nettype none
// A result is registered in the issue stage, alongside the font read, then in the output queue.
// A drawn character is accepted, scrolls first if it wraps, then issues its glyph rows,
// one glyph row per cycle while the output credit allows.
// Loads, carriage returns, empty flushes and ignored items need no further state; a
// flush with damage goes through ST_RECT and a line feed through ST_SCROLL.
// Reset clears the cursor, damage rectangle and output queue; font memory is not cleared.
// ----------------------------------------------------------------------------
// text_console_glyph_renderer: bottom-line text console with 8-pixel glyphs
// Connects the sequencer to the font memory and holds the result pipeline:
// an issue stage aligned with the memory read and a two-entry output queue.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 24,
    parameter int GLYPH_ROWS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [10:0] s_font_index,
    input  wire logic [7:0]  s_font_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [9:0]       m_pixel_x,
    output logic [8:0]       m_pixel_y,
    output logic [7:0]       m_row_bits,
    output logic [9:0]       m_rect_width,
    output logic [8:0]       m_rect_height,
    output logic             m_last
);

    tcgr_pkg::issue_t    issue;
    tcgr_pkg::font_req_t font_req;
    logic [7:0]          font_rdata;
    logic                issue_ok;

    tcgr_pkg::issue_t    stage_reg;
    logic                stage_valid_reg;
    tcgr_pkg::result_t   out_reg, skid_reg, push_res;
    logic                out_valid_reg, skid_valid_reg;
    logic                pop;
    logic [2:0]          pending;

    tcgr_font_ram u_font_ram (
        .aclk  (aclk),
        .req   (font_req),
        .rdata (font_rdata)
    );

    tcgr_ctrl #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS),
        .GLYPH_ROWS   (GLYPH_ROWS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_char_code  (s_char_code),
        .s_font_index (s_font_index),
        .s_font_byte  (s_font_byte),
        .issue_ok     (issue_ok),
        .issue        (issue),
        .font_req     (font_req)
    );

    // Credit: queued plus in-flight results, less a transfer this cycle, must leave room.
    always_comb begin
        pop      = out_valid_reg && m_ready;
        pending  = 3'(out_valid_reg) + 3'(skid_valid_reg) + 3'(stage_valid_reg);
        issue_ok = (pending <= (3'd1 + 3'(pop)));
    end

    // Issue stage lines up with the font read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= issue.valid;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= issue;
    end

    always_comb begin
        push_res = stage_reg.res;
        if (stage_reg.from_ram) begin
            push_res.row_bits = font_rdata;
        end
    end

    // Two-entry output queue: output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= stage_valid_reg;
            end else begin
                out_valid_reg  <= stage_valid_reg;
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= stage_valid_reg;
        end else if (stage_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg  <= skid_reg;
                skid_reg <= push_res;
            end else begin
                out_reg <= push_res;
            end
        end else if (!out_valid_reg) begin
            out_reg <= push_res;
        end else if (stage_valid_reg) begin
            skid_reg <= push_res;
        end
    end

    // Result channel.
    assign m_valid       = out_valid_reg;
    assign m_out_kind    = out_reg.out_kind;
    assign m_pixel_x     = out_reg.pixel_x;
    assign m_pixel_y     = out_reg.pixel_y;
    assign m_row_bits    = out_reg.row_bits;
    assign m_rect_width  = out_reg.rect_width;
    assign m_rect_height = out_reg.rect_height;
    assign m_last        = out_reg.last;

endmodule
`default_nettype wire

FILE: hw/rtl/tcgr_font_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_font_ram: glyph font memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcgr_font_ram (
    input  wire logic                  aclk,
    input  wire tcgr_pkg::font_req_t   req,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [tcgr_pkg::FONT_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port, data valid in the cycle after the request.
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tcgr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_ctrl: console sequencer
// Decodes input items, keeps the cursor and damage rectangle, and issues
// scroll, glyph row and rectangle results one per cycle as credit allows.
// ----------------------------------------------------------------------------
module tcgr_ctrl #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 24,
    parameter int GLYPH_ROWS   = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_kind,
    input  wire logic [7:0]          s_char_code,
    input  wire logic [10:0]         s_font_index,
    input  wire logic [7:0]          s_font_byte,
    input  wire logic                issue_ok,
    output tcgr_pkg::issue_t         issue,
    output tcgr_pkg::font_req_t      font_req
);

    localparam int DIM_W   = tcgr_pkg::DIM_W;
    localparam int FONT_AW = tcgr_pkg::FONT_AW;
    localparam int ROW_W   = $clog2(GLYPH_ROWS);
    localparam int SCREEN_W = TEXT_COLUMNS * tcgr_pkg::GLYPH_COLS;
    localparam int SCREEN_H = TEXT_ROWS * GLYPH_ROWS;
    localparam int ROW_Y0   = GLYPH_ROWS * (TEXT_ROWS - 1);

    localparam logic [DIM_W-1:0]   SCREEN_W_D  = DIM_W'(SCREEN_W);
    localparam logic [DIM_W-1:0]   SCREEN_H_D  = DIM_W'(SCREEN_H);
    localparam logic [DIM_W-1:0]   RIGHT_ALL   = DIM_W'(SCREEN_W - 1);
    localparam logic [DIM_W-1:0]   BOTTOM_ALL  = DIM_W'(SCREEN_H - 1);
    localparam logic [DIM_W-1:0]   ROW_Y0_D    = DIM_W'(ROW_Y0);
    localparam logic [DIM_W-1:0]   ROW_Y1_D    = DIM_W'(ROW_Y0 + GLYPH_ROWS - 1);
    localparam logic [DIM_W-1:0]   GLYPH_W_M1  = DIM_W'(tcgr_pkg::GLYPH_COLS - 1);
    localparam logic [FONT_AW-1:0] GLYPH_ROWS_A = FONT_AW'(GLYPH_ROWS);
    localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [6:0]         COLS_C      = 7'(TEXT_COLUMNS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCROLL = 4'b0010,
        ST_ROWS   = 4'b0100,
        ST_RECT   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [6:0]           cursor_reg, cursor_next;
    logic [DIM_W-1:0]     left_reg, left_next;
    logic [DIM_W-1:0]     top_reg, top_next;
    logic [DIM_W-1:0]     right_reg, right_next;
    logic [DIM_W-1:0]     bottom_reg, bottom_next;
    logic [FONT_AW-1:0]   base_reg, base_next;
    logic [6:0]           col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 scroll_only_reg, scroll_only_next;

    // Character decode of the input item.
    logic [7:0]           chr;
    logic                 is_bs;
    logic [6:0]           col_pre;
    logic                 wrap;
    logic [6:0]           col_draw;
    logic [DIM_W-1:0]     sx;
    logic [DIM_W-1:0]     ex;
    logic [DIM_W-1:0]     bl, bt, br, bb;
    logic [FONT_AW-1:0]   chr_ext;

    always_comb begin
        chr      = (s_char_code > tcgr_pkg::CHAR_MAX) ? tcgr_pkg::CHAR_SPACE : s_char_code;
        is_bs    = (chr == tcgr_pkg::CHAR_BS);
        col_pre  = is_bs ? (cursor_reg - 7'd1) : cursor_reg;
        wrap     = (col_pre >= COLS_C);
        col_draw = wrap ? 7'd0 : col_pre;
        sx       = DIM_W'(col_draw) << tcgr_pkg::GLYPH_COL_SHIFT;
        ex       = sx + GLYPH_W_M1;
        // A wrap damages the whole screen before the new glyph is added.
        bl       = wrap ? '0 : left_reg;
        bt       = wrap ? '0 : top_reg;
        br       = wrap ? RIGHT_ALL : right_reg;
        bb       = wrap ? BOTTOM_ALL : bottom_reg;
        chr_ext  = FONT_AW'(chr);
    end

    // Rectangle and row result fields.
    logic [DIM_W-1:0] rect_w;
    logic [DIM_W-1:0] rect_h;
    logic [DIM_W-1:0] row_y;
    logic [DIM_W-1:0] row_x;

    always_comb begin
        rect_w = (right_reg >= left_reg) ? (right_reg - left_reg + DIM_W'(1)) : '0;
        rect_h = (bottom_reg >= top_reg) ? (bottom_reg - top_reg + DIM_W'(1)) : '0;
        row_y  = ROW_Y0_D + DIM_W'(row_reg);
        row_x  = DIM_W'(col_reg) << tcgr_pkg::GLYPH_COL_SHIFT;
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        left_next        = left_reg;
        top_next         = top_reg;
        right_next       = right_reg;
        bottom_next      = bottom_reg;
        base_next        = base_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        scroll_only_next = scroll_only_reg;

        s_ready          = 1'b0;
        issue            = '0;
        font_req.we      = 1'b0;
        font_req.waddr   = s_font_index;
        font_req.wdata   = s_font_byte;
        font_req.re      = 1'b0;
        font_req.raddr   = base_reg + FONT_AW'(row_reg);

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_kind)
                        tcgr_pkg::IN_LOAD: begin
                            font_req.we = 1'b1;
                        end
                        tcgr_pkg::IN_PUT: begin
                            if (chr == tcgr_pkg::CHAR_CR) begin
                                cursor_next = '0;
                            end else if (chr == tcgr_pkg::CHAR_LF) begin
                                left_next        = '0;
                                top_next         = '0;
                                right_next       = RIGHT_ALL;
                                bottom_next      = BOTTOM_ALL;
                                scroll_only_next = 1'b1;
                                state_next       = ST_SCROLL;
                            end else if (!(is_bs && cursor_reg == 7'd0)) begin
                                // Draw the glyph and widen the damage at once.
                                left_next        = (bl > sx) ? sx : bl;
                                top_next         = (bt > ROW_Y0_D) ? ROW_Y0_D : bt;
                                right_next       = (br < ex) ? ex : br;
                                bottom_next      = (bb < ROW_Y1_D) ? ROW_Y1_D : bb;
                                cursor_next      = is_bs ? col_draw : (col_draw + 7'd1);
                                col_next         = col_draw;
                                base_next        = chr_ext * GLYPH_ROWS_A;
                                row_next         = '0;
                                scroll_only_next = 1'b0;
                                state_next       = wrap ? ST_SCROLL : ST_ROWS;
                            end
                        end
                        tcgr_pkg::IN_FLUSH: begin
                            if (left_reg < SCREEN_W_D) begin
                                state_next = ST_RECT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCROLL: begin
                issue.valid        = issue_ok;
                issue.res.out_kind = tcgr_pkg::OUT_SCROLL;
                issue.res.last     = scroll_only_reg;
                if (issue_ok) begin
                    state_next = scroll_only_reg ? ST_IDLE : ST_ROWS;
                end
            end

            ST_ROWS: begin
                issue.valid        = issue_ok;
                issue.from_ram     = 1'b1;
                issue.res.out_kind = tcgr_pkg::OUT_ROW;
                issue.res.pixel_x  = row_x[9:0];
                issue.res.pixel_y  = row_y[8:0];
                issue.res.last     = (row_reg == ROW_LAST);
                font_req.re        = issue_ok;
                if (issue_ok) begin
                    row_next = row_reg + ROW_W'(1);
                    if (row_reg == ROW_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RECT: begin
                issue.valid           = issue_ok;
                issue.res.out_kind    = tcgr_pkg::OUT_RECT;
                issue.res.pixel_x     = left_reg[9:0];
                issue.res.pixel_y     = top_reg[8:0];
                issue.res.rect_width  = rect_w[9:0];
                issue.res.rect_height = rect_h[8:0];
                issue.res.last        = 1'b1;
                if (issue_ok) begin
                    left_next   = SCREEN_W_D;
                    top_next    = SCREEN_H_D;
                    right_next  = '0;
                    bottom_next = '0;
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and console state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            left_reg   <= SCREEN_W_D;
            top_reg    <= SCREEN_H_D;
            right_reg  <= '0;
            bottom_reg <= '0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

    // Per-item working registers.
    always_ff @(posedge aclk) begin
        base_reg        <= base_next;
        col_reg         <= col_next;
        row_reg         <= row_next;
        scroll_only_reg <= scroll_only_next;
    end

endmodule
`default_nettype wire

FILE: bench/tcgr_bench_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcgr_bench_pkg: console predictor and scoreboard for the glyph renderer bench
// Keeps a private copy of the font memory, the cursor and the damage rectangle.
// From each accepted input transfer it works out the row writes, scrolls and
// rectangles that must follow, and checks every output transfer against them.
// ----------------------------------------------------------------------------
package tcgr_bench_pkg;

    // Console geometry, matching the parameters given to the block.
    localparam int TEXT_COLUMNS  = 80;
    localparam int TEXT_ROWS     = 24;
    localparam int GLYPH_ROWS    = 16;
    localparam int SCREEN_W      = TEXT_COLUMNS * tcgr_pkg::GLYPH_COLS;
    localparam int SCREEN_H      = TEXT_ROWS * GLYPH_ROWS;
    localparam int BOTTOM_LINE_Y = GLYPH_ROWS * (TEXT_ROWS - 1);

    // Input kind that the block ignores.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Only this many faults are printed in detail.
    localparam int REPORT_LIMIT = 10;

    class render_scoreboard;

        logic [7:0]         font_mem [tcgr_pkg::FONT_DEPTH];
        int                 column;
        int                 dmg_left;
        int                 dmg_top;
        int                 dmg_right;
        int                 dmg_bottom;
        tcgr_pkg::result_t  pending[$];
        int                 fault_count;

        function new();
            column      = 0;
            fault_count = 0;
            clear_damage();
        endfunction

        function void clear_damage();
            dmg_left   = SCREEN_W;
            dmg_top    = SCREEN_H;
            dmg_right  = 0;
            dmg_bottom = 0;
        endfunction

        function void damage_screen();
            dmg_left   = 0;
            dmg_top    = 0;
            dmg_right  = SCREEN_W - 1;
            dmg_bottom = SCREEN_H - 1;
        endfunction

        function void push_result(tcgr_pkg::out_kind_t kind, int px, int py,
                                  logic [7:0] bits, int w, int h);
            tcgr_pkg::result_t r;
            r             = '0;
            r.out_kind    = kind;
            r.pixel_x     = 10'(px);
            r.pixel_y     = 9'(py);
            r.row_bits    = bits;
            r.rect_width  = 10'(w);
            r.rect_height = 9'(h);
            pending.push_back(r);
        endfunction

        // Draw one character on the bottom line, handling the control codes.
        function void render_char(logic [7:0] code);
            int glyph;
            int sx;
            bit stepped_back;
            glyph        = (code > tcgr_pkg::CHAR_MAX) ? int'(tcgr_pkg::CHAR_SPACE)
                                                       : int'(code);
            stepped_back = 1'b0;
            if (glyph == tcgr_pkg::CHAR_CR) begin
                column = 0;
                return;
            end
            if (glyph == tcgr_pkg::CHAR_LF) begin
                damage_screen();
                push_result(tcgr_pkg::OUT_SCROLL, 0, 0, 8'h00, 0, 0);
                return;
            end
            if (glyph == tcgr_pkg::CHAR_BS) begin
                if (column == 0)
                    return;
                column       = column - 1;
                stepped_back = 1'b1;
            end
            // The cursor past the right edge wraps with a scroll first.
            if (column >= TEXT_COLUMNS) begin
                column = 0;
                damage_screen();
                push_result(tcgr_pkg::OUT_SCROLL, 0, 0, 8'h00, 0, 0);
            end
            sx = column * tcgr_pkg::GLYPH_COLS;
            for (int y = 0; y < GLYPH_ROWS; y++)
                push_result(tcgr_pkg::OUT_ROW, sx, BOTTOM_LINE_Y + y,
                            font_mem[(glyph * GLYPH_ROWS + y) % tcgr_pkg::FONT_DEPTH],
                            0, 0);
            if (dmg_left > sx)
                dmg_left = sx;
            if (dmg_top > BOTTOM_LINE_Y)
                dmg_top = BOTTOM_LINE_Y;
            if (dmg_right < sx + tcgr_pkg::GLYPH_COLS - 1)
                dmg_right = sx + tcgr_pkg::GLYPH_COLS - 1;
            if (dmg_bottom < BOTTOM_LINE_Y + GLYPH_ROWS - 1)
                dmg_bottom = BOTTOM_LINE_Y + GLYPH_ROWS - 1;
            if (!stepped_back)
                column = (column + 1) % 128;
        endfunction

        // Report the damaged rectangle, if any, and reset it.
        function void report_damage();
            int w;
            int h;
            if (dmg_left >= SCREEN_W)
                return;
            w = (dmg_right >= dmg_left) ? dmg_right - dmg_left + 1 : 0;
            h = (dmg_bottom >= dmg_top) ? dmg_bottom - dmg_top + 1 : 0;
            push_result(tcgr_pkg::OUT_RECT, dmg_left, dmg_top, 8'h00, w, h);
            clear_damage();
        endfunction

        // Note one accepted input transfer and queue what it must cause.
        function void note_item(logic [1:0] kind, logic [7:0] code, logic [10:0] idx,
                                logic [7:0] fbyte);
            int                count_before;
            tcgr_pkg::result_t r;
            count_before = pending.size();
            case (kind)
                tcgr_pkg::IN_LOAD:  font_mem[idx] = fbyte;
                tcgr_pkg::IN_PUT:   render_char(code);
                tcgr_pkg::IN_FLUSH: report_damage();
                default:  ;
            endcase
            // The final result of this item carries the last flag.
            if (pending.size() > count_before) begin
                r      = pending.pop_back();
                r.last = 1'b1;
                pending.push_back(r);
            end
        endfunction

        function string describe(tcgr_pkg::result_t r);
            return $sformatf("kind=%0d x=%0d y=%0d bits=%02h w=%0d h=%0d last=%0d",
                             r.out_kind, r.pixel_x, r.pixel_y, r.row_bits,
                             r.rect_width, r.rect_height, r.last);
        endfunction

        // Check one output transfer against the oldest expectation.
        function void check_result(tcgr_pkg::result_t got);
            tcgr_pkg::result_t want;
            if (pending.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("Unexpected result, nothing pending: %s", describe(got));
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("Result mismatch: expected %s", describe(want));
                    $display("                 actual   %s", describe(got));
                end
            end
        endfunction

    endclass

endpackage

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the text console glyph renderer
// Loads glyphs, draws characters and control codes, and flushes the damaged
// rectangle, with random idle cycles on both channels, a long receiver hold
// and a full drain pause. Every output transfer is checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 90;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 15;
    localparam int HOLD_AT      = 20;
    localparam int PAUSE_AT     = 50;
    localparam int QUIET_FROM   = 55;
    localparam int QUIET_TO     = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_char_code;
    logic [10:0] s_font_index;
    logic [7:0]  s_font_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_out_kind;
    logic [9:0]  m_pixel_x;
    logic [8:0]  m_pixel_y;
    logic [7:0]  m_row_bits;
    logic [9:0]  m_rect_width;
    logic [8:0]  m_rect_height;
    logic        m_last;

    tcgr_bench_pkg::render_scoreboard scoreboard = new();

    // Font entries written so far, so that no unwritten entry is ever drawn.
    bit font_written [tcgr_pkg::FONT_DEPTH];
    int ready_glyphs[$];

    bit tx_gaps;
    bit rx_gaps;
    bit hold_request;
    int cycle_count;
    int random_items;

    text_console_glyph_renderer #(
        .TEXT_COLUMNS (tcgr_bench_pkg::TEXT_COLUMNS),
        .TEXT_ROWS    (tcgr_bench_pkg::TEXT_ROWS),
        .GLYPH_ROWS   (tcgr_bench_pkg::GLYPH_ROWS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_char_code   (s_char_code),
        .s_font_index  (s_font_index),
        .s_font_byte   (s_font_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_row_bits    (m_row_bits),
        .m_rect_width  (m_rect_width),
        .m_rect_height (m_rect_height),
        .m_last        (m_last)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Observe both channels and feed every transfer to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            scoreboard.note_item(s_kind, s_char_code, s_font_index, s_font_byte);
        if (aresetn && m_valid && m_ready)
            scoreboard.check_result(tcgr_pkg::result_t'({m_out_kind, m_pixel_x,
                                                         m_pixel_y, m_row_bits,
                                                         m_rect_width, m_rect_height,
                                                         m_last}));
    end

    // Result receiver with random stalls and one long hold on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !rx_gaps || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one input transfer and wait until it is accepted.
    task automatic send_item(logic [1:0] kind, logic [7:0] code, logic [10:0] idx,
                             logic [7:0] fbyte);
        if (tx_gaps && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_char_code  <= code;
        s_font_index <= idx;
        s_font_byte  <= fbyte;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Wait for the next edge so the last transfer is noted, then until nothing is pending.
    task automatic wait_drained();
        @(posedge aclk);
        while (scoreboard.pending.size() != 0)
            @(posedge aclk);
    endtask

    // Glyph drawn for a code, or -1 for codes that read no glyph.
    function automatic int glyph_of(logic [7:0] code);
        if (code > tcgr_pkg::CHAR_MAX)
            return tcgr_pkg::CHAR_SPACE;
        if (code == tcgr_pkg::CHAR_CR || code == tcgr_pkg::CHAR_LF)
            return -1;
        return code;
    endfunction

    function automatic bit glyph_ready(int glyph);
        for (int r = 0; r < tcgr_bench_pkg::GLYPH_ROWS; r++)
            if (!font_written[glyph * tcgr_bench_pkg::GLYPH_ROWS + r])
                return 1'b0;
        return 1'b1;
    endfunction

    // Load all rows of one glyph; a negative fill gives random rows.
    // The backspace glyph is kept out of the pool of printable glyphs.
    task automatic load_glyph(int glyph, int fill);
        int idx;
        for (int r = 0; r < tcgr_bench_pkg::GLYPH_ROWS; r++) begin
            idx = glyph * tcgr_bench_pkg::GLYPH_ROWS + r;
            send_item(tcgr_pkg::IN_LOAD, 8'($urandom_range(255)), idx[10:0],
                      (fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
            font_written[idx] = 1'b1;
        end
        if (glyph != tcgr_pkg::CHAR_BS)
            ready_glyphs.push_back(glyph);
    endtask

    // Put a character, loading its glyph first when it is still missing.
    task automatic put_code(logic [7:0] code);
        int glyph;
        glyph = glyph_of(code);
        if (glyph >= 0 && !glyph_ready(glyph))
            load_glyph(glyph, -1);
        send_item(tcgr_pkg::IN_PUT, code, 11'($urandom_range(2047)),
                  8'($urandom_range(255)));
    endtask

    task automatic send_flush();
        send_item(tcgr_pkg::IN_FLUSH, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                  8'($urandom_range(255)));
    endtask

    // Stimulus.
    initial begin
        int         line_len;
        int         pick;
        int         idx;
        bit         first_line;
        bit         wrap_line;
        bit         hold_done;
        bit         pause_done;
        logic [7:0] code;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = tcgr_pkg::IN_LOAD;
        s_char_code  = 8'h00;
        s_font_index = 11'h000;
        s_font_byte  = 8'h00;
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        hold_request = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty flush, ignored kind, glyph extremes and control codes.
        send_flush();
        send_item(tcgr_bench_pkg::KIND_UNUSED, 8'hFF, 11'h7FF, 8'hFF);
        load_glyph(tcgr_pkg::CHAR_MAX, 8'hFF);
        load_glyph(tcgr_pkg::CHAR_BS, -1);
        load_glyph(tcgr_pkg::CHAR_SPACE, 8'h00);
        load_glyph(65, -1);
        put_code(8'd65);
        put_code(tcgr_pkg::CHAR_MAX);
        put_code(8'd255);
        put_code(8'd128);
        put_code(tcgr_pkg::CHAR_BS);
        send_flush();
        put_code(tcgr_pkg::CHAR_CR);
        put_code(tcgr_pkg::CHAR_BS);
        put_code(tcgr_pkg::CHAR_LF);
        send_flush();
        send_flush();

        // Random lines of text; the first one draws enough glyphs to wrap.
        random_items = 0;
        first_line   = 1'b1;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            wrap_line = first_line;
            if (first_line)
                line_len = tcgr_bench_pkg::TEXT_COLUMNS + 2;
            else if ($urandom_range(99) < 25)
                line_len = $urandom_range(70, 90);
            else
                line_len = $urandom_range(1, 12);
            first_line = 1'b0;
            for (int i = 0; i < line_len && random_items < RANDOM_ITEMS; i++) begin
                // Phase events: long receiver hold, full drain, quiet stretch.
                if (!hold_done && random_items >= HOLD_AT) begin
                    hold_done    = 1'b1;
                    hold_request = 1'b1;
                end
                if (!pause_done && random_items >= PAUSE_AT) begin
                    pause_done = 1'b1;
                    s_valid <= 1'b0;
                    wait_drained();
                end
                tx_gaps = (random_items < QUIET_FROM || random_items > QUIET_TO);
                rx_gaps = tx_gaps;

                pick = wrap_line ? 99 : $urandom_range(99);
                if (pick < 4) begin
                    put_code(tcgr_pkg::CHAR_BS);
                end else if (pick < 7) begin
                    send_flush();
                end else if (pick < 9) begin
                    send_item(tcgr_bench_pkg::KIND_UNUSED, 8'($urandom_range(255)),
                              11'($urandom_range(2047)), 8'($urandom_range(255)));
                end else if (pick < 12) begin
                    idx = $urandom_range(2047);
                    send_item(tcgr_pkg::IN_LOAD, 8'($urandom_range(255)), idx[10:0],
                              8'($urandom_range(255)));
                    font_written[idx] = 1'b1;
                end else begin
                    // A loaded glyph, or a code above 127 that draws as space.
                    if ($urandom_range(99) < 60)
                        code = 8'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
                    else
                        code = 8'($urandom_range(128, 255));
                    put_code(code);
                end
                random_items++;
            end

            // End of line: carriage return, line feed, both, or just a flush.
            case ($urandom_range(3))
                0: begin
                    put_code(tcgr_pkg::CHAR_CR);
                    random_items++;
                end
                1: begin
                    put_code(tcgr_pkg::CHAR_LF);
                    random_items++;
                end
                2: begin
                    put_code(tcgr_pkg::CHAR_CR);
                    put_code(tcgr_pkg::CHAR_LF);
                    random_items += 2;
                end
                default: begin
                    send_flush();
                    random_items++;
                end
            endcase
        end
        send_flush();

        // Drain and finish.
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.fault_count == 0 && scoreboard.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
